// ----- hdl/rgbaob_pkg.sv -----
// Shared types and constants for the RGBA "over" blender.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rgbaob_pkg;

    localparam int CHAN_W  = 8;     // width of one colour or alpha channel
    localparam int NUM_CH  = 3;     // red, green, blue
    localparam int QUOT_W  = 24;    // colour numerator and quotient width
    localparam int DIV_W   = 9;     // output alpha before saturation, up to 256
    localparam int ROUND_W = 17;    // width of the round-to-nearest sums

    localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'd255;
    localparam logic [DIV_W-1:0]   ALPHA_ONE  = 9'd256;
    localparam logic [ROUND_W-1:0] ROUND_HALF = 17'd128;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_BACK_OPACITY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORE_OPACITY = 1'd1;

    // one colour lane of the divider: partial remainder, and the numerator
    // shifting out at the top while quotient bits shift in at the bottom
    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [QUOT_W-1:0] nq;
    } div_lane_t;

    // word handed from cell to cell along the divider chain
    typedef struct packed {
        div_lane_t [NUM_CH-1:0] lane;
        logic [DIV_W-1:0]       divisor;
        logic [CHAN_W-1:0]      alpha;
        logic                   last;
    } div_word_t;

endpackage

// ----- hdl/rgba_alpha_over_blend.sv -----
// Porter-Duff "over" blend of a straight-alpha RGBA8888 foreground onto a background.
// Takes and returns one pixel per clock while out_ready is high. It has three front
// stages (opacity scaling, output alpha, colour numerators), a row of 24 divider
// cells producing one quotient bit each, and a registered output stage.
// Every stage holds its own valid bit, so bubbles close up and a stalled output
// still lets the pipeline fill. Opacity writes take effect on transactions accepted
// afterwards; write them only while the block is empty.
// Depends on rgbaob_pkg, rgbaob_front, rgbaob_div_cell and rgbaob_out.
`timescale 1ns / 1ps

module rgba_alpha_over_blend
    import rgbaob_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CHAN_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CHAN_W-1:0]      back_red,
    input  logic [CHAN_W-1:0]      back_green,
    input  logic [CHAN_W-1:0]      back_blue,
    input  logic [CHAN_W-1:0]      back_alpha,
    input  logic [CHAN_W-1:0]      fore_red,
    input  logic [CHAN_W-1:0]      fore_green,
    input  logic [CHAN_W-1:0]      fore_blue,
    input  logic [CHAN_W-1:0]      fore_alpha,
    input  logic                   last_pixel_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CHAN_W-1:0]      out_red,
    output logic [CHAN_W-1:0]      out_green,
    output logic [CHAN_W-1:0]      out_blue,
    output logic [CHAN_W-1:0]      out_alpha,
    output logic                   last_pixel_out
);

    logic [CHAN_W-1:0] back_opacity_reg;
    logic [CHAN_W-1:0] fore_opacity_reg;

    // links along the divider chain; index 0 is the front end's output
    logic      [QUOT_W:0] link_valid;
    logic      [QUOT_W:0] link_ready;
    div_word_t [QUOT_W:0] link_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_opacity_reg <= CHAN_MAX;
            fore_opacity_reg <= CHAN_MAX;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BACK_OPACITY: back_opacity_reg <= cfg_data;
                REG_FORE_OPACITY: fore_opacity_reg <= cfg_data;
            endcase
        end
    end

    rgbaob_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .back_opacity (back_opacity_reg),
        .fore_opacity (fore_opacity_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .back_red     (back_red),
        .back_green   (back_green),
        .back_blue    (back_blue),
        .back_alpha   (back_alpha),
        .fore_red     (fore_red),
        .fore_green   (fore_green),
        .fore_blue    (fore_blue),
        .fore_alpha   (fore_alpha),
        .last_pixel_in(last_pixel_in),
        .dn_valid     (link_valid[0]),
        .dn_ready     (link_ready[0]),
        .dn_data      (link_data[0])
    );

    for (genvar i = 0; i < QUOT_W; i++)
    begin : g_cell
        rgbaob_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .up_valid(link_valid[i]),
            .up_ready(link_ready[i]),
            .up_data (link_data[i]),
            .dn_valid(link_valid[i+1]),
            .dn_ready(link_ready[i+1]),
            .dn_data (link_data[i+1])
        );
    end

    rgbaob_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (link_valid[QUOT_W]),
        .up_ready      (link_ready[QUOT_W]),
        .up_data       (link_data[QUOT_W]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .out_alpha     (out_alpha),
        .last_pixel_out(last_pixel_out)
    );

endmodule

// ----- hdl/rgbaob_front.sv -----
// Front end of the blender: opacity scaling, output alpha and colour numerators.
// Three pipeline stages; uses rgbaob_pkg. Feeds the divider cell chain.
`timescale 1ns / 1ps

module rgbaob_front
    import rgbaob_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAN_W-1:0] back_opacity,
    input  logic [CHAN_W-1:0] fore_opacity,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAN_W-1:0] back_red,
    input  logic [CHAN_W-1:0] back_green,
    input  logic [CHAN_W-1:0] back_blue,
    input  logic [CHAN_W-1:0] back_alpha,
    input  logic [CHAN_W-1:0] fore_red,
    input  logic [CHAN_W-1:0] fore_green,
    input  logic [CHAN_W-1:0] fore_blue,
    input  logic [CHAN_W-1:0] fore_alpha,
    input  logic              last_pixel_in,
    output logic              dn_valid,
    input  logic              dn_ready,
    output div_word_t         dn_data
);

    // stage 1: effective alphas
    logic                           s1_valid_reg;
    logic [CHAN_W-1:0]              s1_ab_reg, s1_af_reg;
    logic [NUM_CH-1:0][CHAN_W-1:0]  s1_cb_reg, s1_cf_reg;
    logic                           s1_last_reg;
    logic [CHAN_W-1:0]              s1_ab_next, s1_af_next;

    // stage 2: weights and output alpha
    logic                           s2_valid_reg;
    logic [2*CHAN_W-1:0]            s2_wb_reg;
    logic [NUM_CH-1:0][2*CHAN_W-1:0] s2_pf_reg;
    logic [NUM_CH-1:0][CHAN_W-1:0]  s2_cb_reg;
    logic [DIV_W-1:0]               s2_ao_reg;
    logic                           s2_last_reg;
    logic [2*CHAN_W-1:0]            s2_wb_next;
    logic [NUM_CH-1:0][2*CHAN_W-1:0] s2_pf_next;
    logic [DIV_W-1:0]               s2_ao_next;

    // stage 3: numerators and divisor
    logic                           s3_valid_reg;
    div_word_t                      s3_data_reg;
    div_word_t                      s3_data_next;

    logic s1_ready, s2_ready, s3_ready;

    logic [DIV_W-1:0]   op_back, op_fore, inv_af;
    logic [ROUND_W-1:0] ab_sum, af_sum, ao_sum;

    assign s3_ready = !s3_valid_reg || dn_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // register value 255 stands for full opacity
    always_comb
    begin
        op_back    = (back_opacity == CHAN_MAX) ? ALPHA_ONE : {1'b0, back_opacity};
        op_fore    = (fore_opacity == CHAN_MAX) ? ALPHA_ONE : {1'b0, fore_opacity};
        ab_sum     = ROUND_W'(back_alpha * op_back) + ROUND_HALF;
        af_sum     = ROUND_W'(fore_alpha * op_fore) + ROUND_HALF;
        s1_ab_next = ab_sum[15:8];
        s1_af_next = af_sum[15:8];
    end

    always_comb
    begin
        inv_af     = ALPHA_ONE - {1'b0, s1_af_reg};
        s2_wb_next = (2*CHAN_W)'(s1_ab_reg * inv_af);
        ao_sum     = ROUND_W'({s1_af_reg, 8'd0}) + ROUND_W'(s2_wb_next) + ROUND_HALF;
        s2_ao_next = ao_sum[16:8];
        for (int c = 0; c < NUM_CH; c++)
        begin
            s2_pf_next[c] = s1_af_reg * s1_cf_reg[c];
        end
    end

    always_comb
    begin
        s3_data_next = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            s3_data_next.lane[c].rem = '0;
            s3_data_next.lane[c].nq  = {s2_pf_reg[c], 8'd0}
                                     + QUOT_W'(s2_wb_reg * s2_cb_reg[c]);
        end
        // fully transparent result divides by one
        s3_data_next.divisor = (s2_ao_reg == '0) ? DIV_W'(1) : s2_ao_reg;
        s3_data_next.alpha   = s2_ao_reg[8] ? CHAN_MAX : s2_ao_reg[7:0];
        s3_data_next.last    = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_ab_reg   <= s1_ab_next;
            s1_af_reg   <= s1_af_next;
            s1_cb_reg   <= {back_blue, back_green, back_red};
            s1_cf_reg   <= {fore_blue, fore_green, fore_red};
            s1_last_reg <= last_pixel_in;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_wb_reg   <= s2_wb_next;
            s2_pf_reg   <= s2_pf_next;
            s2_cb_reg   <= s1_cb_reg;
            s2_ao_reg   <= s2_ao_next;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign dn_valid = s3_valid_reg;
    assign dn_data  = s3_data_reg;

endmodule

// ----- hdl/rgbaob_div_cell.sv -----
// One cell of the restoring divider chain: one quotient bit for all three lanes.
// Uses rgbaob_pkg; instantiated QUOT_W times in a row by the top level.
`timescale 1ns / 1ps

module rgbaob_div_cell
    import rgbaob_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  div_word_t up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output div_word_t dn_data
);

    logic      valid_reg;
    div_word_t data_reg;
    div_word_t data_next;

    logic [NUM_CH-1:0][DIV_W-1:0] trial;
    logic [NUM_CH-1:0][DIV_W-1:0] diff;
    logic [NUM_CH-1:0]            ge;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        data_next = up_data;
        for (int c = 0; c < NUM_CH; c++)
        begin
            trial[c] = {up_data.lane[c].rem, up_data.lane[c].nq[QUOT_W-1]};
            ge[c]    = (trial[c] >= up_data.divisor);
            diff[c]  = trial[c] - up_data.divisor;
            // remainder stays below the divisor, so it fits in eight bits
            data_next.lane[c].rem = ge[c] ? diff[c][CHAN_W-1:0] : trial[c][CHAN_W-1:0];
            data_next.lane[c].nq  = {up_data.lane[c].nq[QUOT_W-2:0], ge[c]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- hdl/rgbaob_out.sv -----
// Output stage: rounds and saturates the quotients, holds the result transaction.
// Uses rgbaob_pkg; fed by the last divider cell.
`timescale 1ns / 1ps

module rgbaob_out
    import rgbaob_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  div_word_t         up_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAN_W-1:0] out_red,
    output logic [CHAN_W-1:0] out_green,
    output logic [CHAN_W-1:0] out_blue,
    output logic [CHAN_W-1:0] out_alpha,
    output logic              last_pixel_out
);

    logic                          out_valid_reg;
    logic [NUM_CH-1:0][CHAN_W-1:0] chan_reg;
    logic [CHAN_W-1:0]             alpha_reg;
    logic                          last_reg;

    logic [NUM_CH-1:0][CHAN_W-1:0]  chan_next;
    logic [NUM_CH-1:0][ROUND_W-1:0] rnd;

    assign up_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            rnd[c] = ROUND_W'(up_data.lane[c].nq[15:0]) + ROUND_HALF;
            if ((up_data.lane[c].nq[QUOT_W-1:16] != '0) || rnd[c][16])
            begin
                chan_next[c] = CHAN_MAX;
            end
            else
            begin
                chan_next[c] = rnd[c][15:8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            out_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            chan_reg  <= chan_next;
            alpha_reg <= up_data.alpha;
            last_reg  <= up_data.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_red        = chan_reg[0];
    assign out_green      = chan_reg[1];
    assign out_blue       = chan_reg[2];
    assign out_alpha      = alpha_reg;
    assign last_pixel_out = last_reg;

endmodule
